// File: design/mwc_pkg.sv
// Shared types and constants for the multiply-with-carry random generator.
// No dependencies; every other file of the block depends on this package.
`default_nettype none
package mwc_pkg;

  localparam int DATA_W      = 32;
  localparam int HALF_W      = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_STEPS   = DATA_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [HALF_W-1:0] MUL_A      = 16'd36969;
  localparam logic [HALF_W-1:0] MUL_B      = 16'd18000;
  localparam logic [DATA_W-1:0] SEED_RESET = 32'hBEEF_DEAD;

  // One queued job: the advanced generator halves plus the range request.
  typedef struct packed {
    logic [HALF_W-1:0] lag_a_low;
    logic [DATA_W-1:0] lag_b;
    logic [DATA_W-1:0] range_low;
    logic [DATA_W-1:0] span;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_FINISH
  } back_state_t;

endpackage
`default_nettype wire

// File: design/mwc_if.sv
// Handshake channels of the generator: seed write, request and result.
// Depends on mwc_pkg for the word width.
`default_nettype none
interface mwc_seed_if;
  logic                      valid;
  logic                      ready;
  logic [mwc_pkg::DATA_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mwc_req_if;
  logic                      valid;
  logic                      ready;
  logic [mwc_pkg::DATA_W-1:0] range_low;
  logic [mwc_pkg::DATA_W-1:0] range_high;
  modport source (output valid, output range_low, output range_high, input ready);
  modport sink   (input valid, input range_low, input range_high, output ready);
endinterface

interface mwc_res_if;
  logic                      valid;
  logic                      ready;
  logic [mwc_pkg::DATA_W-1:0] raw_value;
  logic [mwc_pkg::DATA_W-1:0] ranged_value;
  logic                      span_error;
  modport source (output valid, output raw_value, output ranged_value,
                  output span_error, input ready);
  modport sink   (input valid, input raw_value, input ranged_value,
                  input span_error, output ready);
endinterface
`default_nettype wire

// File: design/mwc_random_generator.sv
// Top level of the multiply-with-carry random generator.
// Depends on mwc_pkg, mwc_if, mwc_front, mwc_queue and mwc_back.
//
// Channels: seed (write word, always ready) reloads the two generator halves,
// low 16 bits to the first, high 16 bits to the second. req carries
// range_low/range_high; each accepted request advances both halves once and
// yields one word on res: raw_value, ranged_value and span_error.
// The front end takes a request whenever the queue is not full and queues
// it (two entries). The back end reduces the raw word modulo the span with a
// radix-2 divider, one quotient bit per cycle: each word takes a load, 32
// divide steps and an output step; a zero span skips the divide steps. That
// divider sets the sustained throughput. An accepted request passes the queue,
// the load, the divide steps and the output register before res.valid rises.
// Reset (rst, synchronous) loads the reset seed 0xBEEFDEAD and empties the
// queue and result register. When the receiver stalls, the result word
// holds, the divider finishes its next job and waits, and requests keep being
// taken until the queue is full.
`default_nettype none
module mwc_random_generator (
  input  wire logic clk,
  input  wire logic rst,
  mwc_seed_if.sink  seed,
  mwc_req_if.sink   req,
  mwc_res_if.source res
);
  import mwc_pkg::*;

  logic          push;
  logic          pop;
  job_t          push_data;
  job_t          pop_data;
  queue_status_t qstat;

  mwc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .seed      (seed),
    .req       (req),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  mwc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (qstat)
  );

  mwc_back u_back (
    .clk   (clk),
    .rst   (rst),
    .job   (pop_data),
    .qstat (qstat),
    .pop   (pop),
    .res   (res)
  );

endmodule
`default_nettype wire

// File: design/mwc_front.sv
// Front end: holds the two generator halves, takes seed writes and requests,
// advances the halves per request and queues a job. Depends on mwc_pkg, mwc_if.
`default_nettype none
module mwc_front (
  input  wire logic           clk,
  input  wire logic           rst,
  mwc_seed_if.sink            seed,
  mwc_req_if.sink             req,
  input  mwc_pkg::queue_status_t qstat,
  output logic                push,
  output mwc_pkg::job_t       push_data
);
  import mwc_pkg::*;

  logic [DATA_W-1:0] gen_a;
  logic [DATA_W-1:0] gen_b;
  logic [DATA_W-1:0] gen_a_next;
  logic [DATA_W-1:0] gen_b_next;

  assign seed.ready = 1'b1;
  assign req.ready  = !qstat.full;
  assign push       = req.valid && req.ready;

  // Product fits in 32 bits: 36969 * 0xFFFF + 0xFFFF stays below 2^32.
  assign gen_a_next = {{(DATA_W-HALF_W){1'b0}}, MUL_A} *
                      {{(DATA_W-HALF_W){1'b0}}, gen_a[HALF_W-1:0]} +
                      {{(DATA_W-HALF_W){1'b0}}, gen_a[DATA_W-1:HALF_W]};
  assign gen_b_next = {{(DATA_W-HALF_W){1'b0}}, MUL_B} *
                      {{(DATA_W-HALF_W){1'b0}}, gen_b[HALF_W-1:0]} +
                      {{(DATA_W-HALF_W){1'b0}}, gen_b[DATA_W-1:HALF_W]};

  always_comb begin
    push_data.lag_a_low = gen_a_next[HALF_W-1:0];
    push_data.lag_b     = gen_b_next;
    push_data.range_low = req.range_low;
    push_data.span      = req.range_high - req.range_low;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_a <= {{(DATA_W-HALF_W){1'b0}}, SEED_RESET[HALF_W-1:0]};
      gen_b <= {{(DATA_W-HALF_W){1'b0}}, SEED_RESET[DATA_W-1:HALF_W]};
    end else if (seed.valid && seed.ready) begin
      gen_a <= {{(DATA_W-HALF_W){1'b0}}, seed.data[HALF_W-1:0]};
      gen_b <= {{(DATA_W-HALF_W){1'b0}}, seed.data[DATA_W-1:HALF_W]};
    end else if (push) begin
      gen_a <= gen_a_next;
      gen_b <= gen_b_next;
    end
  end

endmodule
`default_nettype wire

// File: design/mwc_queue.sv
// Short job queue between the front end and the divider back end.
// Depends on mwc_pkg for the job type and depth.
`default_nettype none
module mwc_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  mwc_pkg::job_t          push_data,
  input  wire logic              pop,
  output mwc_pkg::job_t          pop_data,
  output mwc_pkg::queue_status_t status
);
  import mwc_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/mwc_back.sv
// Back end: forms the raw word, reduces it modulo the span with a radix-2
// restoring divider, and holds the result word. Depends on mwc_pkg, mwc_if.
`default_nettype none
module mwc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  mwc_pkg::job_t          job,
  input  mwc_pkg::queue_status_t qstat,
  output logic                   pop,
  mwc_res_if.source              res
);
  import mwc_pkg::*;

  back_state_t          state;
  back_state_t          state_next;
  logic                 load;
  logic                 step;
  logic                 out_load;
  logic                 out_valid;

  logic [DATA_W-1:0]    raw;
  logic [DATA_W-1:0]    dividend;
  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    span;
  logic [DATA_W-1:0]    range_low;
  logic [DIV_CNT_W-1:0] cnt;

  logic [DATA_W-1:0]    raw_in;
  logic [DATA_W:0]      trial;
  logic                 fits;
  logic                 span_zero;

  assign raw_in    = {job.lag_a_low, {HALF_W{1'b0}}} + job.lag_b;
  assign trial     = {rem, dividend[DATA_W-1]};
  assign fits      = (trial >= {1'b0, span});
  assign span_zero = (span == '0);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!qstat.empty) begin
          state_next = (job.span == '0) ? BK_FINISH : BK_DIVIDE;
        end
      end
      BK_DIVIDE: begin
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = BK_FINISH;
        end
      end
      BK_FINISH: begin
        if (out_load) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    load     = 1'b0;
    step     = 1'b0;
    out_load = 1'b0;
    case (state)
      BK_IDLE:   load = !qstat.empty;
      BK_DIVIDE: step = 1'b1;
      BK_FINISH: out_load = !out_valid || res.ready;
      default:   load = 1'b0;
    endcase
  end

  assign pop       = load;
  assign res.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      raw       <= raw_in;
      dividend  <= raw_in;
      rem       <= '0;
      cnt       <= '0;
      span      <= job.span;
      range_low <= job.range_low;
    end else if (step) begin
      // Shift in one dividend bit, subtract the span where it fits.
      rem      <= fits ? DATA_W'(trial - {1'b0, span}) : trial[DATA_W-1:0];
      dividend <= {dividend[DATA_W-2:0], 1'b0};
      cnt      <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.raw_value    <= raw;
      res.ranged_value <= span_zero ? range_low : range_low + rem;
      res.span_error   <= span_zero;
    end
  end

endmodule
`default_nettype wire
